@@ hw/rtl/asda_pkg.sv @@
package asda_pkg;

  localparam int InW        = 16;
  localparam int WinW       = 10;
  localparam int SumW       = 26;
  localparam int DistW      = 16;
  localparam int RadW       = 2 * DistW;
  localparam int RemW       = DistW + 1;
  localparam int CntW       = 5;
  localparam int SampleBitsDef = 16;

  localparam logic [WinW-1:0] WindowReset = WinW'(10);
  localparam logic [31:0]     ScaleFactor = 32'd10000;
  // largest squared sum whose scaled value still fits in 32 bits
  localparam logic [39:0]     ScaleLimit  = 40'd429496;
  localparam logic [DistW-1:0] DistMax    = '1;

  localparam logic [CntW-1:0] SqLast   = CntW'(3);
  localparam logic [CntW-1:0] RootLast = CntW'(DistW - 1);
  localparam logic [CntW-1:0] DivLast  = CntW'(SumW - 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQUARE,
    ST_SCALE,
    ST_ROOT,
    ST_ACCUM,
    ST_DIVIDE,
    ST_OUTPUT
  } asda_state_e;

  typedef struct packed {
    logic       load;
    logic       sq_step;
    logic [1:0] sq_sel;
    logic       scale;
    logic       root_step;
    logic       accum;
    logic       div_step;
    logic       out_load;
  } asda_cmd_t;

  typedef struct packed {
    logic emit;
    logic out_free;
  } asda_status_t;

endpackage

@@ hw/rtl/accel_step_distance_averager_core.sv @@
// channel | direction | handshake                | payload
// input   | in        | in_valid_i / in_stall_o  | accel_x_i, accel_y_i, accel_z_i
// output  | out       | out_valid_o / out_stall_i| average_distance_o
// config  | in        | cfg_we_i                 | cfg_wdata_i
//
// a distance transaction runs the accept cycle, the shared squarer, scale,
// the bit-pair square root and accumulate in that order
// an emitting transaction skips the distance steps and runs the restoring divider
// reset clears the previous sample, count and sum and sets the window to 10
// the output register frees the input side; a held result stalls only the next emit
module accel_step_distance_averager_core
  import asda_pkg::*;
#(
  parameter int SampleBits = SampleBitsDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [InW-1:0]    accel_x_i,
  input  logic [InW-1:0]    accel_y_i,
  input  logic [InW-1:0]    accel_z_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [DistW-1:0]  average_distance_o,
  input  logic              cfg_we_i,
  input  logic [WinW-1:0]   cfg_wdata_i
);

  asda_cmd_t    cmd;
  asda_status_t status;
  logic         busy;
  logic         start;

  assign in_stall_o = busy;
  assign start      = in_valid_i && !busy;

  asda_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start),
    .status_i (status),
    .cmd_o    (cmd),
    .busy_o   (busy)
  );

  asda_dp #(
    .SampleBits (SampleBits)
  ) u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (cmd),
    .status_o           (status),
    .cfg_we_i           (cfg_we_i),
    .cfg_wdata_i        (cfg_wdata_i),
    .accel_x_i          (accel_x_i),
    .accel_y_i          (accel_y_i),
    .accel_z_i          (accel_z_i),
    .out_stall_i        (out_stall_i),
    .out_valid_o        (out_valid_o),
    .average_distance_o (average_distance_o)
  );

endmodule

@@ hw/rtl/asda_ctrl.sv @@
module asda_ctrl
  import asda_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start_i,
  input  asda_status_t status_i,
  output asda_cmd_t    cmd_o,
  output logic         busy_o
);

  asda_state_e     state_q, state_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          state_d = status_i.emit ? ST_DIVIDE : ST_SQUARE;
        end
      end
      ST_SQUARE: begin
        if (cnt_q == SqLast) begin
          state_d = ST_SCALE;
        end
      end
      ST_SCALE: begin
        state_d = ST_ROOT;
      end
      ST_ROOT: begin
        if (cnt_q == RootLast) begin
          state_d = ST_ACCUM;
        end
      end
      ST_ACCUM: begin
        state_d = ST_IDLE;
      end
      ST_DIVIDE: begin
        if (cnt_q == DivLast) begin
          state_d = ST_OUTPUT;
        end
      end
      ST_OUTPUT: begin
        if (status_i.out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign cnt_d = (state_d != state_q) ? '0 : cnt_q + CntW'(1);

  always_comb begin
    cmd_o        = '0;
    cmd_o.sq_sel = cnt_q[1:0];
    busy_o       = 1'b1;
    case (state_q)
      ST_IDLE: begin
        busy_o     = 1'b0;
        cmd_o.load = start_i;
      end
      ST_SQUARE: begin
        cmd_o.sq_step = 1'b1;
      end
      ST_SCALE: begin
        cmd_o.scale = 1'b1;
      end
      ST_ROOT: begin
        cmd_o.root_step = 1'b1;
      end
      ST_ACCUM: begin
        cmd_o.accum = 1'b1;
      end
      ST_DIVIDE: begin
        cmd_o.div_step = 1'b1;
      end
      ST_OUTPUT: begin
        cmd_o.out_load = status_i.out_free;
      end
      default: begin
        busy_o = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  a_emit_to_divide: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE && start_i && status_i.emit) |=> state_q == ST_DIVIDE)
    else $error("emitting transaction did not enter divide");

  a_root_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_ROOT |-> cnt_q <= RootLast)
    else $error("root step count out of range");

  a_div_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIVIDE && cnt_q != DivLast) |=> state_q == ST_DIVIDE)
    else $error("divide left early");

endmodule

@@ hw/rtl/asda_dp.sv @@
module asda_dp
  import asda_pkg::*;
#(
  parameter int SampleBits = SampleBitsDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  asda_cmd_t         cmd_i,
  output asda_status_t      status_o,
  input  logic              cfg_we_i,
  input  logic [WinW-1:0]   cfg_wdata_i,
  input  logic [InW-1:0]    accel_x_i,
  input  logic [InW-1:0]    accel_y_i,
  input  logic [InW-1:0]    accel_z_i,
  input  logic              out_stall_i,
  output logic              out_valid_o,
  output logic [DistW-1:0]  average_distance_o
);

  localparam int SB  = SampleBits;
  localparam int SqW = 2 * SB + 2;

  function automatic logic [SB-1:0] abs_diff(logic [SB-1:0] a, logic [SB-1:0] b);
    logic signed [SB:0] sa;
    logic signed [SB:0] sb;
    logic signed [SB:0] df;
    logic [SB:0]        ng;
    sa = $signed({a[SB-1], a});
    sb = $signed({b[SB-1], b});
    df = sa - sb;
    ng = -df;
    return df[SB] ? ng[SB-1:0] : df[SB-1:0];
  endfunction

  logic [WinW-1:0]  window_q;
  logic [SB-1:0]    prev_x_q, prev_y_q, prev_z_q;
  logic [WinW-1:0]  count_q;
  logic [SumW-1:0]  sum_q;
  logic             out_valid_q;
  logic [DistW-1:0] avg_q;

  logic [SB-1:0]    dx_q, dy_q, dz_q;
  logic [2*SB-1:0]  prod_q;
  logic [SqW-1:0]   sq_sum_q;
  logic             sat_q;
  logic [RadW-1:0]  rad_q;
  logic [RemW-1:0]  rem_q;
  logic [DistW-1:0] root_q;
  logic [SumW-1:0]  div_q;
  logic [WinW-1:0]  drem_q;

  logic [SB-1:0]    sq_op;
  logic [39:0]      sq_ext;
  logic [RemW+1:0]  rem_sh;
  logic [RemW+1:0]  trial;
  logic             root_ge;
  logic [RemW+1:0]  rem_sub;
  logic [WinW:0]    drem_sh;
  logic             div_ge;
  logic [WinW:0]    drem_sub;
  logic [DistW-1:0] step_len;
  logic [DistW-1:0] avg_d;
  logic             emit;

  assign emit = count_q >= window_q;

  always_comb begin
    case (cmd_i.sq_sel)
      2'd0:    sq_op = dx_q;
      2'd1:    sq_op = dy_q;
      2'd2:    sq_op = dz_q;
      default: sq_op = '0;
    endcase
  end

  assign sq_ext  = {{(40-SqW){1'b0}}, sq_sum_q};
  assign rem_sh  = {rem_q, rad_q[RadW-1 -: 2]};
  assign trial   = {1'b0, root_q, 2'b01};
  assign root_ge = rem_sh >= trial;
  assign rem_sub = rem_sh - trial;

  assign drem_sh  = {drem_q, div_q[SumW-1]};
  assign div_ge   = drem_sh >= {1'b0, window_q};
  assign drem_sub = drem_sh - {1'b0, window_q};

  assign step_len = sat_q ? DistMax : root_q;

  always_comb begin
    if (window_q == '0) begin
      avg_d = '0;
    end else if (|div_q[SumW-1:DistW]) begin
      avg_d = DistMax;
    end else begin
      avg_d = div_q[DistW-1:0];
    end
  end

  // architectural state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_q    <= WindowReset;
      prev_x_q    <= '0;
      prev_y_q    <= '0;
      prev_z_q    <= '0;
      count_q     <= '0;
      sum_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        window_q <= cfg_wdata_i;
      end
      if (cmd_i.load) begin
        prev_x_q <= accel_x_i[SB-1:0];
        prev_y_q <= accel_y_i[SB-1:0];
        prev_z_q <= accel_z_i[SB-1:0];
        if (emit) begin
          count_q <= '0;
          sum_q   <= '0;
        end
      end
      if (cmd_i.accum) begin
        count_q <= count_q + WinW'(1);
        sum_q   <= sum_q + {{(SumW-DistW){1'b0}}, step_len};
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      dx_q     <= abs_diff(accel_x_i[SB-1:0], prev_x_q);
      dy_q     <= abs_diff(accel_y_i[SB-1:0], prev_y_q);
      dz_q     <= abs_diff(accel_z_i[SB-1:0], prev_z_q);
      prod_q   <= '0;
      sq_sum_q <= '0;
      div_q    <= sum_q;
      drem_q   <= '0;
    end
    if (cmd_i.sq_step) begin
      prod_q   <= {{SB{1'b0}}, sq_op} * {{SB{1'b0}}, sq_op};
      sq_sum_q <= sq_sum_q + {2'b00, prod_q};
    end
    if (cmd_i.scale) begin
      sat_q  <= sq_ext > ScaleLimit;
      rad_q  <= {13'b0, sq_ext[18:0]} * ScaleFactor;
      rem_q  <= '0;
      root_q <= '0;
    end
    if (cmd_i.root_step) begin
      rem_q  <= root_ge ? rem_sub[RemW-1:0] : rem_sh[RemW-1:0];
      root_q <= {root_q[DistW-2:0], root_ge};
      rad_q  <= {rad_q[RadW-3:0], 2'b00};
    end
    if (cmd_i.div_step) begin
      drem_q <= div_ge ? drem_sub[WinW-1:0] : drem_sh[WinW-1:0];
      div_q  <= {div_q[SumW-2:0], div_ge};
    end
    if (cmd_i.out_load) begin
      avg_q <= avg_d;
    end
  end

  assign status_o.emit     = emit;
  assign status_o.out_free = !out_valid_q || !out_stall_i;

  assign out_valid_o        = out_valid_q;
  assign average_distance_o = avg_q;

  a_valid_from_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(cmd_i.out_load))
    else $error("output valid raised without a result load");

endmodule

@@ tb/sv/accel_step_distance_averager_core_tb.sv @@
module accel_step_distance_averager_core_tb;
  import asda_pkg::*;

  localparam int CycleLimit = 400000;
  localparam int DrainCycles = 40;
  localparam int HoldCycles = 400;
  localparam int RandItems = 540;
  localparam int ReportMax = 10;

  localparam logic [InW-1:0] SMax = 16'h7fff;
  localparam logic [InW-1:0] SMin = 16'h8000;

  typedef enum logic {ROW_WIN, ROW_SAMPLE} row_kind_e;
  typedef enum int {PICK_FULL, PICK_CORNER, PICK_STEP} pick_mode_e;

  typedef struct packed {
    row_kind_e        kind;
    logic [InW-1:0]   x;
    logic [InW-1:0]   y;
    logic [InW-1:0]   z;
    logic [WinW-1:0]  win;
    logic             typed;
    logic [DistW-1:0] avg;
  } dir_row_t;

  localparam int NumDirRows = 25;
  localparam dir_row_t DirRows [NumDirRows] = '{
    '{ROW_SAMPLE, SMax, SMax, SMax, 10'd0, 1'b0, 16'd0},
    '{ROW_SAMPLE, SMin, SMin, SMin, 10'd0, 1'b0, 16'd0},
    '{ROW_SAMPLE, SMax, SMax, SMax, 10'd0, 1'b0, 16'd0},
    '{ROW_SAMPLE, SMin, SMin, SMin, 10'd0, 1'b0, 16'd0},
    '{ROW_SAMPLE, SMax, SMax, SMax, 10'd0, 1'b0, 16'd0},
    '{ROW_SAMPLE, SMin, SMin, SMin, 10'd0, 1'b0, 16'd0},
    '{ROW_SAMPLE, SMax, SMax, SMax, 10'd0, 1'b0, 16'd0},
    '{ROW_SAMPLE, SMin, SMin, SMin, 10'd0, 1'b0, 16'd0},
    '{ROW_SAMPLE, SMax, SMax, SMax, 10'd0, 1'b0, 16'd0},
    '{ROW_SAMPLE, SMin, SMin, SMin, 10'd0, 1'b0, 16'd0},
    // reset window of ten, every distance saturated
    '{ROW_SAMPLE, SMax, SMax, SMax, 10'd0, 1'b1, 16'hffff},
    // zero window emits zero on every transaction
    '{ROW_WIN, 16'd0, 16'd0, 16'd0, 10'd0, 1'b0, 16'd0},
    '{ROW_SAMPLE, 16'd0, 16'd0, 16'd0, 10'd0, 1'b1, 16'd0},
    '{ROW_SAMPLE, 16'd1, 16'd2, 16'd3, 10'd0, 1'b1, 16'd0},
    '{ROW_WIN, 16'd0, 16'd0, 16'd0, 10'd1, 1'b0, 16'd0},
    '{ROW_SAMPLE, 16'hffff, 16'hfffe, 16'hfffd, 10'd0, 1'b0, 16'd0},
    '{ROW_SAMPLE, 16'h0002, 16'hff9c, 16'h0007, 10'd0, 1'b0, 16'd0},
    '{ROW_WIN, 16'd0, 16'd0, 16'd0, 10'd5, 1'b0, 16'd0},
    '{ROW_SAMPLE, SMax, SMax, SMax, 10'd0, 1'b0, 16'd0},
    '{ROW_SAMPLE, SMin, SMin, SMin, 10'd0, 1'b0, 16'd0},
    '{ROW_SAMPLE, SMax, SMax, SMax, 10'd0, 1'b0, 16'd0},
    '{ROW_SAMPLE, SMin, SMin, SMin, 10'd0, 1'b0, 16'd0},
    '{ROW_SAMPLE, SMax, SMax, SMax, 10'd0, 1'b0, 16'd0},
    // window shrunk below the count, quotient saturates
    '{ROW_WIN, 16'd0, 16'd0, 16'd0, 10'd1, 1'b0, 16'd0},
    '{ROW_SAMPLE, SMin, SMin, SMin, 10'd0, 1'b1, 16'hffff}
  };

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             in_valid_i = 1'b0;
  logic             in_stall_o;
  logic [InW-1:0]   accel_x_i = '0;
  logic [InW-1:0]   accel_y_i = '0;
  logic [InW-1:0]   accel_z_i = '0;
  logic             out_valid_o;
  logic             out_stall_i = 1'b0;
  logic [DistW-1:0] average_distance_o;
  logic             cfg_we_i = 1'b0;
  logic [WinW-1:0]  cfg_wdata_i = '0;

  accel_step_distance_averager_core dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .accel_x_i          (accel_x_i),
    .accel_y_i          (accel_y_i),
    .accel_z_i          (accel_z_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .average_distance_o (average_distance_o),
    .cfg_we_i           (cfg_we_i),
    .cfg_wdata_i        (cfg_wdata_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // predictor state
  logic [InW-1:0]  last_x = '0;
  logic [InW-1:0]  last_y = '0;
  logic [InW-1:0]  last_z = '0;
  logic [WinW-1:0] dist_count = '0;
  logic [SumW-1:0] dist_total = '0;
  logic [WinW-1:0] win_len = WindowReset;

  logic [DistW-1:0] expected_avgs [$];

  bit          idle_on = 1'b0;
  int          hold_grant = 0;
  int          hold_seen = 0;
  int          hold_left = 0;
  int          rx_wait = 0;
  int          errors = 0;
  int unsigned cycles = 0;
  int unsigned samples_sent = 0;
  int unsigned avgs_seen = 0;
  int unsigned win_writes = 0;

  task automatic flag_error(string msg);
    errors++;
    if (errors <= ReportMax) $display("mismatch: %s", msg);
  endtask

  function automatic logic [63:0] floor_sqrt(logic [63:0] n);
    logic [63:0] root;
    logic [63:0] cand;
    root = '0;
    for (int i = 31; i >= 0; i--) begin
      cand = root | (64'd1 << i);
      if (cand * cand <= n) root = cand;
    end
    return root;
  endfunction

  function automatic logic [DistW-1:0] step_distance(logic [InW-1:0] ax, logic [InW-1:0] ay,
                                                     logic [InW-1:0] az, logic [InW-1:0] bx,
                                                     logic [InW-1:0] by, logic [InW-1:0] bz);
    logic signed [63:0] ex;
    logic signed [63:0] ey;
    logic signed [63:0] ez;
    logic [63:0]        sq;
    logic [63:0]        root;
    ex = $signed(ax) - $signed(bx);
    ey = $signed(ay) - $signed(by);
    ez = $signed(az) - $signed(bz);
    sq = ex * ex + ey * ey + ez * ez;
    root = floor_sqrt(sq * 64'd10000);
    return (root > 64'(DistMax)) ? DistMax : root[DistW-1:0];
  endfunction

  task automatic predict_sample(logic [InW-1:0] x, logic [InW-1:0] y, logic [InW-1:0] z,
                                output bit emit, output logic [DistW-1:0] avg);
    logic [DistW-1:0] step_len;
    logic [SumW-1:0]  quot;
    step_len = step_distance(x, y, z, last_x, last_y, last_z);
    last_x = x;
    last_y = y;
    last_z = z;
    emit = (dist_count >= win_len);
    avg = '0;
    if (emit) begin
      quot = (win_len == 0) ? '0 : dist_total / SumW'(win_len);
      avg = (quot > SumW'(DistMax)) ? DistMax : quot[DistW-1:0];
      dist_count = '0;
      dist_total = '0;
    end else begin
      dist_count = dist_count + WinW'(1);
      dist_total = dist_total + SumW'(step_len);
    end
  endtask

  task automatic send_sample(logic [InW-1:0] x, logic [InW-1:0] y, logic [InW-1:0] z,
                             logic typed, logic [DistW-1:0] typed_avg);
    int               gap;
    bit               emit;
    logic [DistW-1:0] avg;
    gap = idle_on ? $urandom_range(0, 14) : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    accel_x_i <= x;
    accel_y_i <= y;
    accel_z_i <= z;
    do @(posedge clk_i); while (in_stall_o);
    predict_sample(x, y, z, emit, avg);
    if (typed) expected_avgs.push_back(typed_avg);
    else if (emit) expected_avgs.push_back(avg);
    samples_sent++;
  endtask

  function automatic logic [InW-1:0] pick_axis(logic [InW-1:0] prev, pick_mode_e mode);
    logic [InW-1:0] corner [4];
    corner = '{SMax, SMin, 16'h0000, 16'hffff};
    case (mode)
      PICK_FULL: return InW'($urandom);
      PICK_CORNER: return corner[$urandom_range(0, 3)];
      default: return prev + InW'($urandom_range(0, 1400)) - InW'(700);
    endcase
  endfunction

  task automatic send_random();
    pick_mode_e mode;
    int         r;
    r = $urandom_range(0, 9);
    mode = (r < 2) ? PICK_FULL : (r == 2) ? PICK_CORNER : PICK_STEP;
    send_sample(pick_axis(last_x, mode), pick_axis(last_y, mode), pick_axis(last_z, mode),
                1'b0, '0);
  endtask

  task automatic write_window(logic [WinW-1:0] w);
    in_valid_i <= 1'b0;
    while (expected_avgs.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= w;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    win_len = w;
    win_writes++;
  endtask

  // receiver: checks each average, random stall per result, one long hold-off
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        avgs_seen++;
        if (expected_avgs.size() == 0) begin
          flag_error($sformatf("unexpected average %0d", average_distance_o));
        end else if (average_distance_o !== expected_avgs[0]) begin
          flag_error($sformatf("average expected %0d actual %0d",
                               expected_avgs[0], average_distance_o));
          void'(expected_avgs.pop_front());
        end else begin
          void'(expected_avgs.pop_front());
        end
        rx_wait = idle_on ? $urandom_range(0, 14) : 0;
      end else if (out_valid_o && rx_wait > 0) begin
        rx_wait--;
      end
      if (hold_grant != hold_seen) begin
        hold_seen = hold_grant;
        hold_left = HoldCycles;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= (rx_wait > 0);
      end
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    int              rand_sent;
    int              n;
    logic [WinW-1:0] w;
    rand_sent = 0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    idle_on = 1'b1;
    for (int i = 0; i < NumDirRows; i++) begin
      if (DirRows[i].kind == ROW_WIN) begin
        write_window(DirRows[i].win);
      end else begin
        send_sample(DirRows[i].x, DirRows[i].y, DirRows[i].z, DirRows[i].typed,
                    DirRows[i].avg);
      end
    end

    // back-pressure: output held while input keeps coming
    write_window('0);
    idle_on = 1'b0;
    hold_grant <= hold_grant + 1;
    repeat (30) send_random();

    while (rand_sent < RandItems) begin
      case ($urandom_range(0, 9))
        0: w = '0;
        1: w = '1;
        2: w = 10'd1;
        default: w = WinW'($urandom_range(2, 15));
      endcase
      write_window(w);
      idle_on = ($urandom_range(0, 3) != 0);
      n = $urandom_range(8, 50);
      repeat (n) send_random();
      rand_sent += n;
    end

    in_valid_i <= 1'b0;
    while (expected_avgs.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("ran %0d samples (%0d directed rows) across %0d window writes, %0d averages",
             samples_sent, NumDirRows, win_writes, avgs_seen);
    $display("included a %0d cycle output hold-off with the input backed up", HoldCycles);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

@@ files.f @@
hw/rtl/asda_pkg.sv
hw/rtl/asda_ctrl.sv
hw/rtl/asda_dp.sv
hw/rtl/accel_step_distance_averager_core.sv
tb/sv/accel_step_distance_averager_core_tb.sv
